FILE: sv/lcps_pkg.sv
// Shared constants, codes and control structs of the LED cube layer scanner.
// Used by every module of the block; depends on nothing.
package lcps_pkg;

	// Cube size (2 to 8) and PWM period in ticks (2 to 255).
	localparam int CUBE_EDGE  = 8;
	localparam int PWM_PERIOD = 16;

	// Storage geometry: a frame word holds the eight columns of one row of one layer.
	localparam int ROW_W      = 3;
	localparam int ROWS       = 8;
	localparam int WORD_W     = 64;
	localparam int FRAME_AW   = 6;
	localparam int FRAME_DEPTH = 64;

	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_TICK  = 1'b1;

	typedef struct packed {
		logic                wr_en;
		logic [FRAME_AW-1:0] wr_addr;
		logic [2:0]          wr_col;
		logic [7:0]          wr_data;
		logic                rd_en;
		logic [FRAME_AW-1:0] rd_addr;
	} fm_ctl_t;

	typedef struct packed {
		logic             rd_en;
		logic [ROW_W-1:0] rd_row;
		logic             wr_en;
		logic [ROW_W-1:0] wr_row;
		logic             use_frame;
	} dec_ctl_t;

endpackage

FILE: sv/lcps_if.sv
// Valid/ready channel interfaces for voxel/tick items and for row results.
// Depends on nothing.
interface lcps_in_if;
	logic       valid;
	logic       ready;
	logic       op;
	logic [2:0] x_pos;
	logic [2:0] y_layer;
	logic [2:0] z_pos;
	logic [7:0] brightness;

	modport source (output valid, op, x_pos, y_layer, z_pos, brightness, input ready);
	modport sink   (input valid, op, x_pos, y_layer, z_pos, brightness, output ready);
endinterface

interface lcps_out_if;
	logic       valid;
	logic       ready;
	logic [2:0] row_index;
	logic [7:0] row_bits;
	logic [7:0] layer_mask;
	logic       layer_changed;
	logic       last;

	modport source (output valid, row_index, row_bits, layer_mask, layer_changed, last,
		input ready);
	modport sink   (input valid, row_index, row_bits, layer_mask, layer_changed, last,
		output ready);
endinterface

FILE: sv/lcps_frame_mem.sv
// Frame store: 64 words of eight brightness bytes, byte writes, one registered read.
// Runs a clearing pass after reset. Depends on lcps_pkg.
module lcps_frame_mem (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  lcps_pkg::fm_ctl_t                    ctl,
	output logic [lcps_pkg::WORD_W-1:0]          rd_data,
	output logic                                 busy
);

	logic [lcps_pkg::WORD_W-1:0]   mem [lcps_pkg::FRAME_DEPTH];
	logic [lcps_pkg::FRAME_AW-1:0] clr_addr_q;
	logic                          busy_q;
	logic [lcps_pkg::WORD_W-1:0]   rd_data_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_addr_q <= '0;
			busy_q     <= 1'b1;
		end else if (busy_q) begin
			clr_addr_q <= clr_addr_q + 1'b1;
			if (clr_addr_q == lcps_pkg::FRAME_AW'(lcps_pkg::FRAME_DEPTH - 1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (busy_q) begin
			mem[clr_addr_q] <= '0;
		end else if (ctl.wr_en) begin
			mem[ctl.wr_addr][{ctl.wr_col, 3'b000} +: 8] <= ctl.wr_data;
		end
		if (ctl.rd_en) begin
			rd_data_s1 <= mem[ctl.rd_addr];
		end
	end

	assign rd_data = rd_data_s1;
	assign busy    = busy_q;

endmodule

FILE: sv/lcps_decay_unit.sv
// Per-LED down-counters of the active layer, one 64-bit word per row, and the
// shared eight-lane decrement unit that processes one row per use. Depends on lcps_pkg.
module lcps_decay_unit (
	input  logic                        clk,
	input  logic                        arst_n,
	input  lcps_pkg::dec_ctl_t          ctl,
	input  logic [lcps_pkg::WORD_W-1:0] frame_word,
	output logic [7:0]                  row_bits
);

	logic [lcps_pkg::WORD_W-1:0] cd_mem [lcps_pkg::ROWS];
	logic [lcps_pkg::ROWS-1:0]   vld_q;
	logic [lcps_pkg::WORD_W-1:0] rd_s1;
	logic                        rd_vld_s1;
	logic [lcps_pkg::WORD_W-1:0] src_word;
	logic [lcps_pkg::WORD_W-1:0] new_word;

	// Rows never written since reset read as zero counts.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q     <= '0;
			rd_vld_s1 <= 1'b0;
		end else begin
			if (ctl.rd_en) begin
				rd_vld_s1 <= vld_q[ctl.rd_row];
			end
			if (ctl.wr_en) begin
				vld_q[ctl.wr_row] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.rd_en) begin
			rd_s1 <= cd_mem[ctl.rd_row];
		end
		if (ctl.wr_en) begin
			cd_mem[ctl.wr_row] <= new_word;
		end
	end

	// A layer switch reloads the counters from the frame store before decrementing.
	assign src_word = ctl.use_frame ? frame_word : (rd_vld_s1 ? rd_s1 : '0);

	always_comb begin
		logic [7:0] cnt;
		logic       nz;
		new_word = '0;
		row_bits = '0;
		for (int c = 0; c < 8; c++) begin
			cnt = src_word[c*8 +: 8];
			nz  = (cnt != 8'd0) && (c < lcps_pkg::CUBE_EDGE);
			row_bits[c]        = nz;
			new_word[c*8 +: 8] = cnt - {7'd0, nz};
		end
	end

endmodule

FILE: sv/led_cube_layer_pwm_scanner.sv
// Top level of the LED cube layer PWM scanner: item sequencer, PWM phase and layer
// state, and the row result register. Depends on lcps_pkg, lcps_if, lcps_frame_mem
// and lcps_decay_unit.
//
// After reset the frame store runs a clearing pass, one word per cycle, during which
// no item is taken. A tick first starts the read of row 0 and then steps through the
// rows in order: every row passes once through the single read port of the counter
// store (or of the frame store on a layer switch) and the shared eight-lane decrement
// unit, and the next row is read while the current one is written back. Output stalls
// hold the sequencer; the next item is taken while the last row result still waits
// in the output register.
module led_cube_layer_pwm_scanner (
	input  logic        clk,
	input  logic        arst_n,
	lcps_in_if.sink     item,
	lcps_out_if.source  row
);

	typedef enum logic {
		ST_IDLE,
		ST_ROW
	} state_t;

	state_t                          state_q;
	logic [7:0]                      phase_q;
	logic [lcps_pkg::ROW_W-1:0]      layer_q;
	logic [lcps_pkg::ROW_W-1:0]      row_q;
	logic                            switched_q;
	logic                            out_valid_q;
	logic [2:0]                      row_index_q;
	logic [7:0]                      row_bits_q;
	logic [7:0]                      layer_mask_q;
	logic                            layer_changed_q;
	logic                            last_q;

	lcps_pkg::fm_ctl_t               fm_ctl;
	lcps_pkg::dec_ctl_t              dec_ctl;
	logic [lcps_pkg::WORD_W-1:0]     frame_word;
	logic                            busy;
	logic [7:0]                      bits;

	logic                            accept;
	logic                            tick_acc;
	logic                            in_range;
	logic                            wrap;
	logic [lcps_pkg::ROW_W-1:0]      next_layer;
	logic                            fire;
	logic                            last_row;
	logic [lcps_pkg::ROW_W-1:0]      rd_row;
	logic [7:0]                      enable;

	assign item.ready = (state_q == ST_IDLE) && !busy;
	assign accept     = item.valid && item.ready;
	assign tick_acc   = accept && (item.op == lcps_pkg::OP_TICK);
	assign in_range   = ({1'b0, item.x_pos} < 4'(lcps_pkg::CUBE_EDGE))
		&& ({1'b0, item.y_layer} < 4'(lcps_pkg::CUBE_EDGE))
		&& ({1'b0, item.z_pos} < 4'(lcps_pkg::CUBE_EDGE));
	assign wrap       = phase_q >= 8'(lcps_pkg::PWM_PERIOD - 1);
	assign next_layer = (layer_q == lcps_pkg::ROW_W'(lcps_pkg::CUBE_EDGE - 1))
		? '0 : layer_q + 1'b1;
	assign fire       = (state_q == ST_ROW) && (!out_valid_q || row.ready);
	assign last_row   = row_q == lcps_pkg::ROW_W'(lcps_pkg::CUBE_EDGE - 1);
	assign rd_row     = tick_acc ? '0 : row_q + 1'b1;
	assign enable     = 8'd1 << layer_q;

	always_comb begin
		fm_ctl.wr_en   = accept && (item.op == lcps_pkg::OP_WRITE) && in_range;
		fm_ctl.wr_addr = {item.x_pos, item.y_layer};
		fm_ctl.wr_col  = item.z_pos;
		fm_ctl.wr_data = item.brightness;
		fm_ctl.rd_en   = tick_acc || (fire && !last_row);
		fm_ctl.rd_addr = {rd_row, tick_acc ? next_layer : layer_q};

		dec_ctl.rd_en     = fm_ctl.rd_en;
		dec_ctl.rd_row    = rd_row;
		dec_ctl.wr_en     = fire;
		dec_ctl.wr_row    = row_q;
		dec_ctl.use_frame = switched_q;
	end

	lcps_frame_mem u_frame (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (fm_ctl),
		.rd_data (frame_word),
		.busy    (busy)
	);

	lcps_decay_unit u_decay (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (dec_ctl),
		.frame_word (frame_word),
		.row_bits   (bits)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= ST_IDLE;
			phase_q         <= 8'(lcps_pkg::PWM_PERIOD);
			layer_q         <= lcps_pkg::ROW_W'(lcps_pkg::CUBE_EDGE - 1);
			row_q           <= '0;
			switched_q      <= 1'b0;
			out_valid_q     <= 1'b0;
			row_index_q     <= '0;
			row_bits_q      <= '0;
			layer_mask_q    <= '0;
			layer_changed_q <= 1'b0;
			last_q          <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (tick_acc) begin
						if (wrap) begin
							phase_q <= '0;
							layer_q <= next_layer;
						end else begin
							phase_q <= phase_q + 1'b1;
						end
						switched_q <= wrap;
						row_q      <= '0;
						state_q    <= ST_ROW;
					end
				end
				ST_ROW: begin
					if (fire) begin
						row_q <= row_q + 1'b1;
						if (last_row) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase

			if (fire) begin
				out_valid_q     <= 1'b1;
				row_index_q     <= row_q;
				row_bits_q      <= bits;
				// On a layer switch the enable stays off until all rows are loaded.
				layer_mask_q    <= (switched_q && !last_row) ? 8'd0 : enable;
				layer_changed_q <= switched_q;
				last_q          <= last_row;
			end else if (row.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign row.valid         = out_valid_q;
	assign row.row_index     = row_index_q;
	assign row.row_bits      = row_bits_q;
	assign row.layer_mask    = layer_mask_q;
	assign row.layer_changed = layer_changed_q;
	assign row.last          = last_q;

endmodule

FILE: sv/lcps_checker.sv
// Port-level checks on the row result channel of the LED cube layer scanner,
// bound to the top level. Depends on lcps_pkg and led_cube_layer_pwm_scanner.
module lcps_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_ready,
	input logic [2:0] row_index,
	input logic [7:0] row_bits,
	input logic [7:0] layer_mask,
	input logic       layer_changed,
	input logic       last
);

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid
			&& $stable({row_index, row_bits, layer_mask, layer_changed, last}))
		else $error("row result changed while stalled");

	a_last_row: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (last == (row_index == 3'(lcps_pkg::CUBE_EDGE - 1))))
		else $error("last flag does not match the final row");

	a_mask_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !layer_changed |-> $onehot(layer_mask))
		else $error("layer enable not one-hot on an ordinary tick");

	a_switch_blank: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && layer_changed && !last |-> layer_mask == 8'd0)
		else $error("layer enable on while a layer switch loads rows");

	a_switch_enable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && layer_changed && last |-> $onehot(layer_mask))
		else $error("no layer enable at the end of a layer switch");

endmodule

bind led_cube_layer_pwm_scanner lcps_checker u_lcps_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.out_valid     (row.valid),
	.out_ready     (row.ready),
	.row_index     (row.row_index),
	.row_bits      (row.row_bits),
	.layer_mask    (row.layer_mask),
	.layer_changed (row.layer_changed),
	.last          (row.last)
);
